@@ rtl/hspe_pkg.sv @@
// Shared types, constants and arithmetic helpers of the high shelf presence enhancer.
// Used by the stream interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps

package hspe_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int COEF_WIDTH   = 32;
  localparam int COEF_FRAC    = COEF_WIDTH - 5;
  localparam int BOOST_FRAC   = 14;
  localparam int BOOST_WIDTH  = 16;
  localparam int CFG_WIDTH    = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int HIST_WIDTH   = 32;

  // width of one rounded coefficient product
  localparam int MUL_W  = COEF_WIDTH + HIST_WIDTH;
  localparam int PROD_W = MUL_W - COEF_FRAC;
  // five product terms need three guard bits
  localparam int ACC_W  = PROD_W + 3;

  localparam int DIFF_W   = HIST_WIDTH + 1;
  localparam int BMUL_W   = DIFF_W + BOOST_WIDTH + 1;
  localparam int BPROD_W  = BMUL_W - BOOST_FRAC;
  localparam int RES_W    = BPROD_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PASSTHROUGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHELF_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_AMOUNT = 3'd7;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [HIST_WIDTH-1:0]   hist_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [ACC_W-1:0]        acc_t;
  typedef logic        [BOOST_WIDTH-1:0]  boost_t;

  localparam coef_t COEF_ONE = coef_t'(64'sd1 <<< COEF_FRAC);

  // round_half_up(c * v / 2^COEF_FRAC)
  function automatic prod_t coef_mul(coef_t c, hist_t v);
    logic signed [MUL_W-1:0] full;
    full = MUL_W'(c) * MUL_W'(v);
    full = full + (MUL_W'(1) <<< (COEF_FRAC - 1));
    return full[MUL_W-1:COEF_FRAC];
  endfunction

  // clamp to 32-bit signed
  function automatic hist_t sat_hist(acc_t a);
    hist_t r;
    if (a[ACC_W-1:HIST_WIDTH-1] == '0 || a[ACC_W-1:HIST_WIDTH-1] == '1) begin
      r = a[HIST_WIDTH-1:0];
    end else if (a[ACC_W-1]) begin
      r = {1'b1, {(HIST_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(HIST_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

  // clamp to the sample range
  function automatic sample_t sat_sample(logic signed [RES_W-1:0] a);
    sample_t r;
    if (a[RES_W-1:SAMPLE_WIDTH-1] == '0 || a[RES_W-1:SAMPLE_WIDTH-1] == '1) begin
      r = a[SAMPLE_WIDTH-1:0];
    end else if (a[RES_W-1]) begin
      r = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ rtl/hspe_in_if.sv @@
// Input sample stream: valid/ready handshake carrying one sample per request.
// Depends on hspe_pkg.
`timescale 1ns / 1ps

interface hspe_in_if
  import hspe_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

@@ rtl/hspe_out_if.sv @@
// Output sample stream: valid/ready handshake carrying one sample per request.
// Depends on hspe_pkg.
`timescale 1ns / 1ps

interface hspe_out_if
  import hspe_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

@@ rtl/high_shelf_presence_enhancer_unit.sv @@
// Top level of the high shelf presence enhancer: biquad shelf, presence boost, clamp.
// Depends on hspe_pkg, hspe_in_if and hspe_out_if.
`timescale 1ns / 1ps

// Usage:
//   in_stream  carries one signed Q1.23 sample per request (valid/ready).
//   out_stream returns one processed sample per request, in input order.
//   cfg_we / cfg_index / cfg_data write one register per cycle; write only
//   while no request is in flight.
// Pipeline: three register stages, A, B and the output register; a request
//   taken into stage A passes through B before out_stream.valid is set.
//   Stage A forms the feedforward sum b0*x + b1*x1 + b2*x2.
//   Stage B subtracts a1*y1 + a2*y2 and saturates, or passes x when the shelf is
//   off; y1 comes from this stage's own register, so the feedback loop closes here.
//   Stage C applies the presence boost and clamps to the sample range.
// Throughput: one sample per cycle unless the output stalls; the stage B feedback
//   loop (two coefficient multipliers and a three-input add) sets the clock period.
// Reset: clears all histories and the pipeline, and loads passthrough = 1,
//   shelf off, b0 = 1.0, other coefficients and boost amount 0.
// Stall: each stage holds while the next is full and blocked; empty stages
//   keep filling, so up to three requests are taken while the output waits.
module high_shelf_presence_enhancer_unit
  import hspe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  hspe_in_if.sink              in_stream,
  hspe_out_if.source           out_stream,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  // configuration
  logic   passthrough;
  logic   shelf_enable;
  coef_t  coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  boost_t boost_amount;

  // filter state
  sample_t shelf_in_hist1, shelf_in_hist2;
  hist_t   shelf_out_hist1, shelf_out_hist2;
  hist_t   boost_prev_in;

  // pipeline registers
  logic    a_valid, b_valid, out_valid;
  sample_t a_x, b_x;
  acc_t    a_ff;
  hist_t   b_v;
  sample_t out_sample;

  logic  out_go, b_go, a_go, accept;
  acc_t  ff_next;
  acc_t  acc;
  hist_t v_next;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [BMUL_W-1:0]  boost_mul;
  logic signed [RES_W-1:0]   res;
  sample_t out_next;

  assign out_go = !out_valid || out_stream.ready;
  assign b_go   = !b_valid || out_go;
  assign a_go   = !a_valid || b_go;
  assign in_stream.ready = a_go;
  assign accept = in_stream.valid && a_go;

  assign out_stream.valid      = out_valid;
  assign out_stream.sample_out = out_sample;

  // stage A: feedforward terms
  always_comb begin
    ff_next = acc_t'(coef_mul(coef_b0, hist_t'(in_stream.sample_in)))
            + acc_t'(coef_mul(coef_b1, hist_t'(shelf_in_hist1)))
            + acc_t'(coef_mul(coef_b2, hist_t'(shelf_in_hist2)));
  end

  // stage B: feedback terms and saturation
  always_comb begin
    acc = a_ff
        - acc_t'(coef_mul(coef_a1, shelf_out_hist1))
        - acc_t'(coef_mul(coef_a2, shelf_out_hist2));
    v_next = shelf_enable ? sat_hist(acc) : hist_t'(a_x);
  end

  // stage C: presence boost and clamp
  always_comb begin
    diff = DIFF_W'(b_v) - DIFF_W'(boost_prev_in);
    boost_mul = BMUL_W'($signed({1'b0, boost_amount})) * BMUL_W'(diff);
    boost_mul = boost_mul + (BMUL_W'(1) <<< (BOOST_FRAC - 1));
    res = RES_W'(b_v) + RES_W'($signed(boost_mul[BMUL_W-1:BOOST_FRAC]));
    out_next = passthrough ? b_x : sat_sample(res);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      passthrough  <= 1'b1;
      shelf_enable <= 1'b0;
      coef_b0      <= COEF_ONE;
      coef_b1      <= '0;
      coef_b2      <= '0;
      coef_a1      <= '0;
      coef_a2      <= '0;
      boost_amount <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PASSTHROUGH:  passthrough  <= cfg_data[0];
        REG_SHELF_ENABLE: shelf_enable <= cfg_data[0];
        REG_COEF_B0:      coef_b0      <= coef_t'(cfg_data);
        REG_COEF_B1:      coef_b1      <= coef_t'(cfg_data);
        REG_COEF_B2:      coef_b2      <= coef_t'(cfg_data);
        REG_COEF_A1:      coef_a1      <= coef_t'(cfg_data);
        REG_COEF_A2:      coef_a2      <= coef_t'(cfg_data);
        REG_BOOST_AMOUNT: boost_amount <= cfg_data[BOOST_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid         <= 1'b0;
      b_valid         <= 1'b0;
      out_valid       <= 1'b0;
      shelf_in_hist1  <= '0;
      shelf_in_hist2  <= '0;
      shelf_out_hist1 <= '0;
      shelf_out_hist2 <= '0;
      boost_prev_in   <= '0;
    end else begin
      if (a_go) begin
        a_valid <= in_stream.valid;
      end
      if (accept && !passthrough && shelf_enable) begin
        shelf_in_hist2 <= shelf_in_hist1;
        shelf_in_hist1 <= in_stream.sample_in;
      end
      if (b_go) begin
        b_valid <= a_valid;
      end
      if (b_go && a_valid && !passthrough && shelf_enable) begin
        shelf_out_hist2 <= shelf_out_hist1;
        shelf_out_hist1 <= v_next;
      end
      if (out_go) begin
        out_valid <= b_valid;
      end
      // hold the previous boost input across passthrough requests
      if (out_go && b_valid && !passthrough) begin
        boost_prev_in <= b_v;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_x  <= in_stream.sample_in;
      a_ff <= ff_next;
    end
    if (b_go && a_valid) begin
      b_x <= a_x;
      b_v <= v_next;
    end
    if (out_go && b_valid) begin
      out_sample <= out_next;
    end
  end

endmodule
